[rtl/itfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfs_pkg
// Shared types, register indexes and helper functions for the integer to
// float scale/offset converter.
// ----------------------------------------------------------------------------
package itfs_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WORD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HALF   = 2'd3;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] SINGLE_INF  = 32'h7F80_0000;
    localparam logic [15:0] HALF_INF    = 16'h7C00;
    localparam logic [15:0] HALF_QNAN   = 16'h7E00;

    // Pipeline tag that travels with every request.
    typedef struct packed {
        logic valid;
        logic last;
    } itfs_tag_t;

    // Number of leading zeros of a 64-bit word; 64 for zero.
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] cnt;
        cnt = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                cnt = 7'(63 - i);
            end
        end
        return cnt;
    endfunction

    // Shift right by sh (1..63), rounding to nearest with ties to even.
    function automatic logic [63:0] round_shr(input logic [63:0] mag,
                                              input logic [5:0] sh);
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] m;
        rem  = mag & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 6'd1);
        m    = mag >> sh;
        if (rem > half || (rem == half && m[0])) begin
            m = m + 64'd1;
        end
        return m;
    endfunction

endpackage

[rtl/int_to_float_scale_offset.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_float_scale_offset
// Unsigned pixel sample to IEEE float with fused scale*x+offset, single or
// half precision output.
// ----------------------------------------------------------------------------
// One sample is accepted every clock cycle while the output is not stalled,
// and each request gives exactly one result after passing through an input
// register, six stages of the fused multiply-add (multiply, normalize, align,
// add, exponent, round) and the output register that also does the optional
// half-precision rounding. The whole pipeline advances whenever the output
// register is empty or being taken, so a stalled result holds every stage in
// place. Configuration writes are taken in every cycle and must only be issued
// while no request is in flight.
module int_to_float_scale_offset
    import itfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_sample,
    input  logic                 s_last_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_result_bits,
    output logic                 m_last_out
);

    logic [31:0] scale_reg, offset_reg;
    logic        source_is_word_reg, dest_is_half_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg          <= 32'h3F80_0000;
            offset_reg         <= 32'd0;
            source_is_word_reg <= 1'b1;
            dest_is_half_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE:       scale_reg          <= cfg_data;
                CFG_OFFSET:      offset_reg         <= cfg_data;
                CFG_SOURCE_WORD: source_is_word_reg <= cfg_data[0];
                CFG_DEST_HALF:   dest_is_half_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic advance;
    logic m_valid_reg;
    logic [31:0] m_result_bits_reg;
    logic m_last_out_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // Input register.
    itfs_tag_t   in_tag_reg;
    logic [15:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tag_reg <= '0;
        end else if (advance) begin
            in_tag_reg.valid <= s_valid;
            in_tag_reg.last  <= s_last_in;
        end
        if (advance) begin
            sample_reg <= s_sample;
        end
    end

    logic [15:0] x_masked;
    assign x_masked = source_is_word_reg ? sample_reg : {8'd0, sample_reg[7:0]};

    itfs_tag_t   fma_tag;
    logic [31:0] fma_bits;

    itfs_fma u_fma (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .in_tag      (in_tag_reg),
        .x           (x_masked),
        .scale_bits  (scale_reg),
        .offset_bits (offset_reg),
        .out_tag     (fma_tag),
        .out_bits    (fma_bits)
    );

    // Single to half, round to nearest even, overflow to infinity.
    logic [7:0]  hex;
    logic [22:0] hfr;
    logic [23:0] hm;
    logic [6:0]  hsh;
    logic [63:0] hrnd;
    logic [7:0]  hb;
    logic [18:0] hpack;
    logic [15:0] half_bits;

    always_comb begin
        hex   = fma_bits[30:23];
        hfr   = fma_bits[22:0];
        hm    = {1'b1, hfr};
        hsh   = (hex >= 8'd113) ? 7'd13 : 7'(8'd126 - hex);
        hrnd  = 64'd0;
        hb    = 8'd0;
        hpack = 19'd0;
        if (hex == 8'hFF) begin
            if (hfr == 23'd0) begin
                half_bits = {fma_bits[31], HALF_INF[14:0]};
            end else begin
                half_bits = {fma_bits[31], HALF_QNAN[14:0] | {5'd0, hfr[22:13]}};
            end
        end else if (hex == 8'd0) begin
            // Single subnormals are far below the smallest half subnormal.
            half_bits = {fma_bits[31], 15'd0};
        end else begin
            if (hsh < 7'd25) begin
                hrnd = round_shr({40'd0, hm}, hsh[5:0]);
            end
            hb    = hex - 8'd126 + {1'b0, hsh};
            hpack = {1'b0, hb, 10'd0} + {7'd0, hrnd[11:0]};
            if (hpack >= {3'd0, HALF_INF}) begin
                hpack = {3'd0, HALF_INF};
            end
            half_bits = {fma_bits[31], hpack[14:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= fma_tag.valid;
        end
        if (advance) begin
            m_last_out_reg    <= fma_tag.last;
            m_result_bits_reg <= dest_is_half_reg ? {16'd0, half_bits} : fma_bits;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_bits = m_result_bits_reg;
    assign m_last_out    = m_last_out_reg;

    // In half mode the upper half of the result word is always clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && dest_is_half_reg) |-> (m_result_bits[31:16] == 16'd0))
        else $error("half result has upper bits set");

    // A held result freezes the request in the last arithmetic stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(fma_tag) && $stable(fma_bits)))
        else $error("pipeline moved during output stall");

    // Reset empties the output.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

[rtl/itfs_fma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfs_fma
// Six-stage pipelined fused multiply-add scale*x+offset with a single
// round-to-nearest-even to IEEE single precision.
// ----------------------------------------------------------------------------
module itfs_fma
    import itfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  itfs_tag_t   in_tag,
    input  logic [15:0] x,
    input  logic [31:0] scale_bits,
    input  logic [31:0] offset_bits,
    output itfs_tag_t   out_tag,
    output logic [31:0] out_bits
);

    // ---------------- stage A: decode and multiply ----------------
    itfs_tag_t          a_tag_reg;
    logic [39:0]        a_prod_reg;
    logic [23:0]        a_mo_reg;
    logic signed [10:0] a_ep_reg, a_eo_reg;
    logic               a_sp_reg, a_so_reg, a_force_reg;
    logic [31:0]        a_fval_reg;

    logic [7:0]         se, oe;
    logic [22:0]        sf, of;
    logic               sp, so;
    logic [23:0]        sig_s, sig_o;
    logic               force_next;
    logic [31:0]        fval_next;

    always_comb begin
        se    = scale_bits[30:23];
        sf    = scale_bits[22:0];
        sp    = scale_bits[31];
        oe    = offset_bits[30:23];
        of    = offset_bits[22:0];
        so    = offset_bits[31];
        sig_s = {(se != 8'd0), sf};
        sig_o = {(oe != 8'd0), of};
        force_next = 1'b1;
        fval_next  = 32'd0;
        if (se == 8'hFF && sf != 23'd0) begin
            fval_next = scale_bits | QUIET_BIT;
        end else if (oe == 8'hFF && of != 23'd0) begin
            fval_next = offset_bits | QUIET_BIT;
        end else if (se == 8'hFF) begin
            if (x == 16'd0 || (oe == 8'hFF && so != sp)) begin
                fval_next = DEFAULT_NAN;
            end else begin
                fval_next = {sp, SINGLE_INF[30:0]};
            end
        end else if (oe == 8'hFF) begin
            fval_next = offset_bits;
        end else if ((sig_s == 24'd0 || x == 16'd0) && sig_o == 24'd0) begin
            fval_next = {(sp & so), 31'd0};
        end else begin
            force_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_tag_reg <= '0;
        end else if (en) begin
            a_tag_reg <= in_tag;
        end
        if (en) begin
            a_prod_reg  <= sig_s * x;
            a_mo_reg    <= sig_o;
            a_ep_reg    <= ((se != 8'd0) ? $signed({3'd0, se}) : 11'sd1) - 11'sd150;
            a_eo_reg    <= ((oe != 8'd0) ? $signed({3'd0, oe}) : 11'sd1) - 11'sd150;
            a_sp_reg    <= sp;
            a_so_reg    <= so;
            a_force_reg <= force_next;
            a_fval_reg  <= fval_next;
        end
    end

    // ---------------- stage B: normalize both terms, top bit at 62 ----------------
    itfs_tag_t          b_tag_reg;
    logic [63:0]        b_np_reg, b_no_reg;
    logic signed [10:0] b_ep_reg, b_eo_reg;
    logic               b_pz_reg, b_oz_reg, b_sp_reg, b_so_reg, b_force_reg;
    logic [31:0]        b_fval_reg;

    logic [6:0]         lzp, lzo;

    always_comb begin
        lzp = lzc64({24'd0, a_prod_reg});
        lzo = lzc64({40'd0, a_mo_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_tag_reg <= '0;
        end else if (en) begin
            b_tag_reg <= a_tag_reg;
        end
        if (en) begin
            b_np_reg    <= ({24'd0, a_prod_reg} << lzp) >> 1;
            b_no_reg    <= ({40'd0, a_mo_reg} << lzo) >> 1;
            b_ep_reg    <= a_ep_reg - $signed({4'd0, lzp}) + 11'sd1;
            b_eo_reg    <= a_eo_reg - $signed({4'd0, lzo}) + 11'sd1;
            b_pz_reg    <= (a_prod_reg == 40'd0);
            b_oz_reg    <= (a_mo_reg == 24'd0);
            b_sp_reg    <= a_sp_reg;
            b_so_reg    <= a_so_reg;
            b_force_reg <= a_force_reg;
            b_fval_reg  <= a_fval_reg;
        end
    end

    // ---------------- stage C: order and align with sticky ----------------
    itfs_tag_t          c_tag_reg;
    logic [63:0]        c_a_reg, c_b_reg;
    logic signed [10:0] c_ea_reg;
    logic               c_sa_reg, c_sub_reg, c_force_reg;
    logic [31:0]        c_fval_reg;

    logic               pick_p, bzero, sb;
    logic [63:0]        big, small_raw, small_al;
    logic signed [10:0] ea, eb, d;

    always_comb begin
        pick_p = b_oz_reg | (!b_pz_reg && (b_ep_reg > b_eo_reg ||
                 (b_ep_reg == b_eo_reg && b_np_reg >= b_no_reg)));
        big       = pick_p ? b_np_reg : b_no_reg;
        small_raw = pick_p ? b_no_reg : b_np_reg;
        ea        = pick_p ? b_ep_reg : b_eo_reg;
        eb        = pick_p ? b_eo_reg : b_ep_reg;
        sb        = pick_p ? b_so_reg : b_sp_reg;
        bzero     = pick_p ? b_oz_reg : b_pz_reg;
        d         = ea - eb;
        if (bzero) begin
            small_al = 64'd0;
        end else if (d >= 11'sd64) begin
            small_al = 64'd1;
        end else if (d == 11'sd0) begin
            small_al = small_raw;
        end else begin
            small_al = (small_raw >> d[5:0]) |
                       {63'd0, ((small_raw & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_tag_reg <= '0;
        end else if (en) begin
            c_tag_reg <= b_tag_reg;
        end
        if (en) begin
            c_a_reg     <= big;
            c_b_reg     <= small_al;
            c_ea_reg    <= ea;
            c_sa_reg    <= pick_p ? b_sp_reg : b_so_reg;
            c_sub_reg   <= (pick_p ? b_sp_reg : b_so_reg) != sb;
            c_force_reg <= b_force_reg;
            c_fval_reg  <= b_fval_reg;
        end
    end

    // ---------------- stage D: add or subtract ----------------
    itfs_tag_t          d_tag_reg;
    logic [63:0]        d_sum_reg;
    logic signed [10:0] d_ea_reg;
    logic               d_sa_reg, d_force_reg;
    logic [31:0]        d_fval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_tag_reg <= '0;
        end else if (en) begin
            d_tag_reg <= c_tag_reg;
        end
        if (en) begin
            d_sum_reg   <= c_sub_reg ? (c_a_reg - c_b_reg) : (c_a_reg + c_b_reg);
            d_ea_reg    <= c_ea_reg;
            d_sa_reg    <= c_sa_reg;
            d_force_reg <= c_force_reg;
            d_fval_reg  <= c_fval_reg;
        end
    end

    // ---------------- stage E: result exponent and rounding shift ----------------
    itfs_tag_t          e_tag_reg;
    logic [63:0]        e_sum_reg;
    logic signed [10:0] e_k_reg, e_shift_reg;
    logic               e_sa_reg, e_force_reg, e_zero_reg;
    logic [31:0]        e_fval_reg;

    logic [6:0]         lzs, nbits;
    logic signed [10:0] k;

    always_comb begin
        lzs   = lzc64(d_sum_reg);
        nbits = 7'd64 - lzs;
        k     = d_ea_reg + $signed({4'd0, nbits}) - 11'sd24;
        // Results below the normal range keep the subnormal unit.
        if (k < -11'sd149) begin
            k = -11'sd149;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_tag_reg <= '0;
        end else if (en) begin
            e_tag_reg <= d_tag_reg;
        end
        if (en) begin
            e_sum_reg   <= d_sum_reg;
            e_k_reg     <= k;
            e_shift_reg <= k - d_ea_reg;
            e_sa_reg    <= d_sa_reg;
            e_force_reg <= d_force_reg;
            e_zero_reg  <= (d_sum_reg == 64'd0);
            e_fval_reg  <= d_fval_reg;
        end
    end

    // ---------------- stage F: round and pack ----------------
    itfs_tag_t          f_tag_reg;
    logic [31:0]        f_bits_reg;

    logic [63:0]        m;
    logic signed [10:0] neg_sh, kb;
    logic [32:0]        packed_w;
    logic [31:0]        res_next;

    always_comb begin
        neg_sh = -e_shift_reg;
        if (e_shift_reg <= 11'sd0) begin
            m = e_sum_reg << neg_sh[5:0];
        end else if (e_shift_reg >= 11'sd64) begin
            m = 64'd0;
        end else begin
            m = round_shr(e_sum_reg, e_shift_reg[5:0]);
        end
        kb       = e_k_reg + 11'sd149;
        packed_w = {kb[9:0], 23'd0} + {8'd0, m[24:0]};
        if (packed_w >= {1'b0, SINGLE_INF}) begin
            packed_w = {1'b0, SINGLE_INF};
        end
        if (e_force_reg) begin
            res_next = e_fval_reg;
        end else if (e_zero_reg) begin
            res_next = 32'd0;
        end else begin
            res_next = {e_sa_reg, packed_w[30:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_tag_reg <= '0;
        end else if (en) begin
            f_tag_reg <= e_tag_reg;
        end
        if (en) begin
            f_bits_reg <= res_next;
        end
    end

    assign out_tag  = f_tag_reg;
    assign out_bits = f_bits_reg;

endmodule
